/* rtl/core/pps_pkg.sv */
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;
    localparam logic [23:0] SUM_MAX  = 24'hFF_FFFF;

    // Operation codes carried in the action field
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
    } pps_in_t;

    typedef struct packed {
        logic [3:0]  ran_slot;
        logic        idle;
        logic        finished;
        logic [15:0] completion_time;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
        logic [23:0] total_waiting;
        logic [23:0] total_turnaround;
        logic        all_done;
    } pps_out_t;

    // One job as held in the job memory
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } job_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } sched_state_t;

endpackage

`default_nettype wire

/* rtl/core/preemptive_priority_scheduler_unit.sv */
// Preemptive priority scheduler top level: control FSM, selection and statistics.
// Depends on pps_pkg and pps_job_store.
`timescale 1ns / 1ps
`default_nettype none

// A load beat appends a job (arrival, burst, priority) to the next free slot of
// the job memory with no result; loads with a zero burst or
// into a full table are dropped. A tick beat scans the loaded jobs one slot per
// cycle through the single read port of the job memory, keeps the best ready
// job (smallest priority, then earliest arrival, then lowest slot), writes back
// its decremented remaining work, advances time and emits one result beat. The
// update of a tick waits while the previous result still sits unaccepted in the
// output register. Only one beat is in work at a time; a result waits in the
// output register while the next beat is taken.
// Time saturates at 65535 and the waiting and turnaround totals at 16777215.
module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCESSES = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  pps_pkg::pps_in_t    s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output pps_pkg::pps_out_t   m_data
);
    import pps_pkg::*;

    localparam int AW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    // Control state
    sched_state_t state_reg, state_next;
    logic [CW-1:0] job_count_reg, job_count_next;
    logic [CW-1:0] fin_count_reg, fin_count_next;
    logic [15:0]   time_reg, time_next;
    logic [23:0]   wsum_reg, wsum_next;
    logic [23:0]   tsum_reg, tsum_next;
    logic [AW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [AW-1:0] rd_slot_reg, rd_slot_next;
    logic          found_reg, found_next;
    logic          m_valid_reg, m_valid_next;

    // Payload state
    job_entry_t    best_reg, best_next;
    logic [AW-1:0] best_slot_reg, best_slot_next;
    pps_out_t      m_data_reg, m_data_next;

    // Memory port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    job_entry_t    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    job_entry_t    rd_data;

    // Result datapath
    logic          cand_ready;
    logic          cand_better;
    logic          out_free;
    logic          fin;
    logic [15:0]   comp;
    logic [15:0]   tat;
    logic [15:0]   wt;
    logic [24:0]   wsum_add;
    logic [24:0]   tsum_add;
    logic [CW-1:0] fin_count_upd;

    pps_job_store #(
        .DEPTH (MAX_PROCESSES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Selection: the entry on the read port against the best so far. Strict
    // compares keep the earlier slot on a full tie, since slots come in order.
    assign cand_ready  = (rd_data.arrival <= time_reg) && (rd_data.remaining != 16'd0);
    assign cand_better = !found_reg
                      || (rd_data.prio < best_reg.prio)
                      || ((rd_data.prio == best_reg.prio)
                          && (rd_data.arrival < best_reg.arrival));

    // Completion figures of the selected job
    assign fin      = found_reg && (best_reg.remaining == 16'd1);
    assign comp     = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 16'd1;
    assign tat      = comp - best_reg.arrival;
    assign wt       = (tat >= best_reg.burst) ? tat - best_reg.burst : 16'd0;
    assign wsum_add = {1'b0, wsum_reg} + 25'(wt);
    assign tsum_add = {1'b0, tsum_reg} + 25'(tat);
    assign fin_count_upd = fin ? fin_count_reg + CW'(1) : fin_count_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            fin_count_reg <= '0;
            time_reg      <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_slot_reg   <= '0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            fin_count_reg <= fin_count_next;
            time_reg      <= time_next;
            wsum_reg      <= wsum_next;
            tsum_reg      <= tsum_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            rd_slot_reg   <= rd_slot_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        job_count_next = job_count_reg;
        fin_count_next = fin_count_reg;
        time_next      = time_reg;
        wsum_next      = wsum_reg;
        tsum_next      = tsum_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_slot_next   = rd_slot_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        s_ready = (state_reg == ST_IDLE);
        wr_en   = 1'b0;
        wr_addr = job_count_reg[AW-1:0];
        wr_data = '{arrival:   s_data.arrival_time,
                    burst:     s_data.burst_time,
                    remaining: s_data.burst_time,
                    prio:      s_data.priority_req};
        rd_en   = 1'b0;
        rd_addr = scan_cnt_reg;

        // Fold in the entry read last cycle
        if (rd_vld_reg && cand_ready && cand_better) begin
            found_next     = 1'b1;
            best_next      = rd_data;
            best_slot_next = rd_slot_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACT_LOAD) begin
                        // Append unless the table is full or the burst is empty
                        if ((job_count_reg < CW'(MAX_PROCESSES))
                            && (s_data.burst_time != 16'd0)) begin
                            wr_en          = 1'b1;
                            job_count_next = job_count_reg + CW'(1);
                        end
                    end else begin
                        found_next    = 1'b0;
                        scan_cnt_next = '0;
                        // No jobs: skip the scan, the tick is idle
                        state_next    = (job_count_reg == '0) ? ST_UPDATE : ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one slot read per cycle
                rd_en         = 1'b1;
                rd_vld_next   = 1'b1;
                rd_slot_next  = scan_cnt_reg;
                scan_cnt_next = scan_cnt_reg + AW'(1);
                if (CW'(scan_cnt_reg) + CW'(1) == job_count_reg) begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN: begin
                // Last read data is folded in above
                state_next = ST_UPDATE;
            end

            ST_UPDATE: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    if (found_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = best_slot_reg;
                        wr_data = '{arrival:   best_reg.arrival,
                                    burst:     best_reg.burst,
                                    remaining: best_reg.remaining - 16'd1,
                                    prio:      best_reg.prio};
                    end
                    if (fin) begin
                        wsum_next = wsum_add[24] ? SUM_MAX : wsum_add[23:0];
                        tsum_next = tsum_add[24] ? SUM_MAX : tsum_add[23:0];
                    end
                    fin_count_next = fin_count_upd;
                    if (time_reg != TIME_MAX) begin
                        time_next = time_reg + 16'd1;
                    end

                    m_valid_next                = 1'b1;
                    m_data_next.ran_slot        = found_reg ? 4'(best_slot_reg) : 4'd0;
                    m_data_next.idle            = !found_reg;
                    m_data_next.finished        = fin;
                    m_data_next.completion_time = fin ? comp : 16'd0;
                    m_data_next.turnaround_time = fin ? tat : 16'd0;
                    m_data_next.waiting_time    = fin ? wt : 16'd0;
                    m_data_next.total_waiting   = wsum_next;
                    m_data_next.total_turnaround = tsum_next;
                    m_data_next.all_done        = (fin_count_upd == job_count_reg);
                    state_next                  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Never finish more jobs than were loaded
    a_fin_le_jobs: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_count_reg <= job_count_reg)
        else $error("finished count exceeds job count");

    // The table never holds more than its depth
    a_jobs_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        job_count_reg <= CW'(MAX_PROCESSES))
        else $error("job count beyond table depth");

    // No write-back while a scan is reading the memory
    a_no_wr_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !wr_en)
        else $error("memory write during scan");

    // A new result comes only from the update step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("result raised outside update");

    // A finished job is never reported on an idle tick
    a_fin_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && fin) |-> found_reg && (job_count_reg != '0))
        else $error("completion without a selected job");

endmodule

`default_nettype wire

/* rtl/core/pps_job_store.sv */
// Job memory: one write port, one read port, registered read data.
// Depends on pps_pkg for the job entry type.
`timescale 1ns / 1ps
`default_nettype none

module pps_job_store #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire  [AW-1:0]             wr_addr,
    input  pps_pkg::job_entry_t       wr_data,
    input  wire                       rd_en,
    input  wire  [AW-1:0]             rd_addr,
    output pps_pkg::job_entry_t       rd_data
);
    import pps_pkg::*;

    job_entry_t mem [DEPTH];
    job_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* tb/tb_preemptive_priority_scheduler_unit.sv */
// Self-checking testbench for preemptive_priority_scheduler_unit: job table
// mirror, expected tick reports and valid/ready drivers. Needs pps_pkg and the RTL.
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_unit;

    import pps_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int JOB_SLOTS      = 16;
    localparam int RAND_ITEMS     = 1760;
    // Keep the table partly empty through the random part so that the closing
    // phase still has free slots to fill
    localparam int RAND_JOB_CAP   = 10;
    localparam int MAX_GAP        = 60;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 2 * (JOB_SLOTS + 4);
    localparam int WATCHDOG_LIMIT = 2000;

    // Mirror of the job table: replays every accepted beat and queues the
    // tick report that the block must return for it.
    class sched_mirror;
        logic [15:0] arr_tbl   [JOB_SLOTS];
        logic [15:0] burst_tbl [JOB_SLOTS];
        logic [15:0] rem_tbl   [JOB_SLOTS];
        logic [7:0]  prio_tbl  [JOB_SLOTS];
        int          job_cnt;
        int          done_cnt;
        logic [15:0] cur_time;
        logic [23:0] wait_sum;
        logic [23:0] tat_sum;
        pps_out_t    tick_reports_q[$];
        int          errors;

        function new();
            job_cnt  = 0;
            done_cnt = 0;
            cur_time = '0;
            wait_sum = '0;
            tat_sum  = '0;
            errors   = 0;
        endfunction

        function void take_beat(pps_in_t beat);
            pps_out_t    rpt;
            int          best;
            bit          found;
            logic [15:0] comp;
            logic [15:0] tat;
            logic [15:0] wt;
            logic [24:0] acc;
            if (beat.action == ACT_LOAD) begin
                // Drop loads into a full table and loads with no work
                if (job_cnt < JOB_SLOTS && beat.burst_time != '0) begin
                    arr_tbl[job_cnt]   = beat.arrival_time;
                    burst_tbl[job_cnt] = beat.burst_time;
                    rem_tbl[job_cnt]   = beat.burst_time;
                    prio_tbl[job_cnt]  = beat.priority_req;
                    job_cnt++;
                end
                return;
            end
            rpt   = '0;
            found = 1'b0;
            best  = 0;
            // Smallest priority wins, then earlier arrival, then lower slot
            for (int s = 0; s < job_cnt; s++) begin
                if (arr_tbl[s] <= cur_time && rem_tbl[s] != '0) begin
                    if (!found || prio_tbl[s] < prio_tbl[best] ||
                        (prio_tbl[s] == prio_tbl[best] && arr_tbl[s] < arr_tbl[best])) begin
                        best  = s;
                        found = 1'b1;
                    end
                end
            end
            rpt.idle = !found;
            if (found) begin
                rpt.ran_slot = 4'(best);
                rem_tbl[best] = rem_tbl[best] - 16'd1;
                if (rem_tbl[best] == '0) begin
                    comp = (cur_time == TIME_MAX) ? TIME_MAX : cur_time + 16'd1;
                    tat  = comp - arr_tbl[best];
                    // Once time has saturated the waiting time can go negative: clamp
                    wt   = (tat >= burst_tbl[best]) ? tat - burst_tbl[best] : '0;
                    acc      = {1'b0, wait_sum} + 25'(wt);
                    wait_sum = acc[24] ? SUM_MAX : acc[23:0];
                    acc      = {1'b0, tat_sum} + 25'(tat);
                    tat_sum  = acc[24] ? SUM_MAX : acc[23:0];
                    done_cnt++;
                    rpt.finished        = 1'b1;
                    rpt.completion_time = comp;
                    rpt.turnaround_time = tat;
                    rpt.waiting_time    = wt;
                end
            end
            if (cur_time != TIME_MAX)
                cur_time = cur_time + 16'd1;
            rpt.total_waiting    = wait_sum;
            rpt.total_turnaround = tat_sum;
            rpt.all_done         = (done_cnt == job_cnt);
            tick_reports_q.push_back(rpt);
        endfunction

        function void check_report(pps_out_t got);
            pps_out_t want;
            string    bad;
            if (tick_reports_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result beat with no tick pending: %p", $time, got);
                return;
            end
            want = tick_reports_q.pop_front();
            bad  = "";
            if (got.ran_slot !== want.ran_slot)                 bad = {bad, " ran_slot"};
            if (got.idle !== want.idle)                         bad = {bad, " idle"};
            if (got.finished !== want.finished)                 bad = {bad, " finished"};
            if (got.completion_time !== want.completion_time)   bad = {bad, " completion_time"};
            if (got.turnaround_time !== want.turnaround_time)   bad = {bad, " turnaround_time"};
            if (got.waiting_time !== want.waiting_time)         bad = {bad, " waiting_time"};
            if (got.total_waiting !== want.total_waiting)       bad = {bad, " total_waiting"};
            if (got.total_turnaround !== want.total_turnaround) bad = {bad, " total_turnaround"};
            if (got.all_done !== want.all_done)                 bad = {bad, " all_done"};
            if (bad != "") begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] tick report mismatch in%s", $time, bad);
                    $display("    expected %p", want);
                    $display("    actual   %p", got);
                end
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    pps_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    pps_out_t    m_data;

    sched_mirror mirror;
    int unsigned stall_pct   = 0;
    int unsigned quiet_cycles = 0;

    preemptive_priority_scheduler_unit #(
        .MAX_PROCESSES(JOB_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Receiver: drop ready at random, stall_pct cycles out of a hundred
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted result beat; end the run if the handshakes go quiet
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_report(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("** preemptive_priority_scheduler_unit: FAILED **");
            $finish;
        end
    end

    function automatic pps_in_t make_job(logic [15:0] at, logic [15:0] bt, logic [7:0] pr);
        pps_in_t beat;
        beat.action       = ACT_LOAD;
        beat.arrival_time = at;
        beat.burst_time   = bt;
        beat.priority_req = pr;
        return beat;
    endfunction

    // A tick ignores the job fields, so fill them with noise
    function automatic pps_in_t make_tick();
        pps_in_t beat;
        beat.action       = ACT_TICK;
        beat.arrival_time = 16'($urandom);
        beat.burst_time   = 16'($urandom);
        beat.priority_req = 8'($urandom);
        return beat;
    endfunction

    // Job that is either already due or arrives a little later; priorities
    // mostly from a narrow range so that ties are common
    function automatic pps_in_t random_job();
        logic [15:0] at;
        logic [15:0] bt;
        logic [7:0]  pr;
        if ($urandom_range(3) == 0)
            at = 16'($urandom_range(mirror.cur_time));
        else
            at = mirror.cur_time + 16'($urandom_range(200, 1));
        if ($urandom_range(9) == 0)
            bt = 16'($urandom_range(3, 1));
        else
            bt = 16'($urandom_range(120, 1));
        if ($urandom_range(9) < 7)
            pr = 8'($urandom_range(3));
        else
            pr = 8'($urandom);
        return make_job(at, bt, pr);
    endfunction

    // Short job due within a few ticks, for filling the table quickly
    function automatic pps_in_t short_job();
        return make_job(mirror.cur_time + 16'($urandom_range(8)),
                        16'($urandom_range(4, 1)), 8'($urandom_range(3)));
    endfunction

    function automatic pps_in_t next_random_beat();
        int unsigned roll;
        roll = $urandom_range(999);
        // Zero-burst loads are dropped by the block: background noise
        if (roll < 30)
            return make_job(16'($urandom), 16'd0, 8'($urandom));
        if (roll < 36 && mirror.job_cnt < RAND_JOB_CAP)
            return random_job();
        return make_tick();
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic push_beat(input pps_in_t beat, input int unsigned gap_pct);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < gap_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        mirror.take_beat(beat);
    endtask

    task automatic run_random(input int unsigned gap_pct, input int unsigned stall);
        stall_pct <= stall;
        repeat (RAND_ITEMS / 4) push_beat(next_random_beat(), gap_pct);
    endtask

    initial begin
        mirror = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn   <= 1'b1;
        stall_pct <= 0;
        @(posedge aclk);

        // Directed: empty table, dropped load, ties and preemption
        push_beat(make_tick(), 0);                       // no jobs: idle, all done
        push_beat(make_job(16'd0, 16'd0, 8'd0), 0);      // zero burst: drop
        push_beat(make_job(16'd3, 16'd3, 8'd255), 0);    // low priority, runs first
        push_beat(make_job(16'd5, 16'd1, 8'd0), 0);      // same priority and arrival
        push_beat(make_job(16'd5, 16'd2, 8'd0), 0);      //   as the slot above
        push_beat(make_job(16'd4, 16'd2, 8'd0), 0);      // earlier arrival, higher slot
        repeat (12) push_beat(make_tick(), 0);

        // Random part over the idling phases
        run_random(0, 0);
        run_random(69, 0);
        run_random(0, 69);
        run_random(17, 17);

        // Fill the free slots with short jobs, then run every job to completion
        stall_pct <= 17;
        push_beat(make_job(mirror.cur_time, 16'd3, 8'd0), 17);
        push_beat(make_job(mirror.cur_time, 16'd2, 8'd0), 17);
        while (mirror.job_cnt < JOB_SLOTS - 1)
            push_beat(short_job(), 17);
        while (mirror.done_cnt != mirror.job_cnt)
            push_beat(make_tick(), 17);
        // Last slot: due only at the time limit, so it stays pending
        push_beat(make_job(TIME_MAX, TIME_MAX, 8'd255), 17);
        repeat (4) push_beat(make_tick(), 17);
        // Table full: these loads must be dropped
        repeat (3) push_beat(make_job(16'($urandom), 16'($urandom_range(65535, 1)),
                                      8'($urandom)), 17);
        repeat (4) push_beat(make_tick(), 17);
        s_valid <= 1'b0;

        // Wait for every outstanding report, then let the block settle
        while (mirror.tick_reports_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.errors == 0 && mirror.tick_reports_q.size() == 0)
            $display("** preemptive_priority_scheduler_unit: PASSED **");
        else
            $display("** preemptive_priority_scheduler_unit: FAILED **");
        $finish;
    end

endmodule
